// File: rtl/core/ldcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcs_pkg: shared types and constants
// Payload structs, cell record and chain control for the face to coordinate
// sparsity converter.
// ----------------------------------------------------------------------------
package ldcs_pkg;

	localparam int MAX_FACES = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int FACE_W    = $clog2(MAX_FACES);
	localparam int CNT_W     = FACE_W + 1;
	localparam int CELL_W    = 10;
	localparam int SLOT_W    = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_FACES = 2'd1;

	typedef struct packed {
		logic              kind;
		logic [CELL_W-1:0] owner_cell;
		logic [CELL_W-1:0] neighbour_cell;
	} in_t;

	typedef struct packed {
		logic [CELL_W-1:0] row_index;
		logic [CELL_W-1:0] col_index;
		logic [SLOT_W-1:0] value_slot;
		logic              last_entry;
		logic              status;
	} out_t;

	typedef struct packed {
		logic              vld;
		logic [CELL_W-1:0] owner;
		logic [CELL_W-1:0] nb;
		logic [FACE_W-1:0] face;
	} cell_t;

	typedef struct packed {
		logic ins;
		logic rot;
		logic clr;
	} chain_ctl_t;

	typedef enum logic [2:0] {
		PH_LOWER = 3'b001,
		PH_DIAG  = 3'b010,
		PH_UPPER = 3'b100
	} phase_t;

endpackage

// File: rtl/core/ldcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcs_cell: one sorting cell
// Holds one face; takes a new face, its left neighbour, or its right
// neighbour, keeping the chain sorted on insertion.
// ----------------------------------------------------------------------------
module ldcs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ldcs_pkg::chain_ctl_t ctl,
	input  logic               by_nb,
	input  ldcs_pkg::cell_t    new_c,
	input  ldcs_pkg::cell_t    left_c,
	input  logic               left_gt,
	input  ldcs_pkg::cell_t    right_c,
	output ldcs_pkg::cell_t    cur,
	output logic               gt
);
	import ldcs_pkg::*;

	logic                vld_q;
	logic [CELL_W-1:0]   owner_q;
	logic [CELL_W-1:0]   nb_q;
	logic [FACE_W-1:0]   face_q;
	cell_t               cell_q;
	cell_t               nxt;
	logic [2*CELL_W-1:0] key_self;
	logic [2*CELL_W-1:0] key_new;

	assign cell_q = {vld_q, owner_q, nb_q, face_q};

	always_comb begin
		key_self = by_nb ? {cell_q.nb, cell_q.owner} : {cell_q.owner, cell_q.nb};
		key_new  = by_nb ? {new_c.nb, new_c.owner} : {new_c.owner, new_c.nb};
		gt       = !cell_q.vld || (key_self > key_new);
		nxt      = cell_q;
		if (ctl.clr) begin
			nxt.vld = 1'b0;
		end else if (ctl.rot) begin
			nxt = right_c;
		end else if (ctl.ins) begin
			if (left_gt) begin
				nxt = left_c;
			end else if (gt) begin
				nxt = new_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		owner_q <= nxt.owner;
		nb_q    <= nxt.nb;
		face_q  <= nxt.face;
	end

	assign cur = cell_q;

endmodule

// File: rtl/core/ldcs_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcs_chain: sorted chain of cells
// Insertion sort on load, circular rotation on read; the head is cell zero.
// ----------------------------------------------------------------------------
module ldcs_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ldcs_pkg::chain_ctl_t ctl,
	input  logic                 by_nb,
	input  ldcs_pkg::cell_t      new_c,
	output ldcs_pkg::cell_t      head
);
	import ldcs_pkg::*;

	cell_t cells [MAX_FACES];
	logic  gts   [MAX_FACES];

	for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
		cell_t left_c;
		logic  left_gt;
		cell_t right_c;
		if (i == 0) begin : g_first
			assign left_c  = '0;
			assign left_gt = 1'b0;
		end else begin : g_mid
			assign left_c  = cells[i-1];
			assign left_gt = gts[i-1];
		end
		if (i == MAX_FACES - 1) begin : g_last
			assign right_c = cells[0];
		end else begin : g_inner
			assign right_c = cells[i+1];
		end
		ldcs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.by_nb   (by_nb),
			.new_c   (new_c),
			.left_c  (left_c),
			.left_gt (left_gt),
			.right_c (right_c),
			.cur     (cells[i]),
			.gt      (gts[i])
		);
	end

	assign head = cells[0];

endmodule

// File: rtl/core/ldu_to_coo_sparsity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldu_to_coo_sparsity: face-addressed to row-ordered coordinate converter
// Faces are sorted into two cell chains as they load; fetches stream the
// lower, diagonal and upper entries of each row from the chain heads.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_t  (kind, owner, neighbour)
// out      output     out_valid/out_stall out_t (row, col, slot, last, status)
// cfg      input      cfg_valid/cfg_ready index, data
//
// A load inserts the face into both chains in parallel.
// A fetch pops the lookahead buffer and the generator refills it; skipped
// faces, the step from lower to diagonal in each row and each row change
// also take generator steps.
// Reset empties both chains; a config write mid-stream rotates the chains
// back into order with the input stalled.
// ----------------------------------------------------------------------------
module ldu_to_coo_sparsity (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ldcs_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ldcs_pkg::out_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ldcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldcs_pkg::CNT_W-1:0]      cfg_data
);
	import ldcs_pkg::*;

	logic [CNT_W-1:0]  num_rows_q, num_faces_q, count_q, lpop_q, upop_q;
	logic [CNT_W-1:0]  nf, nr;
	logic              stream_q, gen_on_q, end_q, realign_q, out_valid_q;
	logic [1:0]        bcnt_q;
	logic [CELL_W-1:0] row_q;
	phase_t            ph_q, ph_d;
	out_t              buf0_q, buf1_q, out_q, gen_e, resp;
	cell_t             lhead, uhead, new_c;
	chain_ctl_t        lctl, uctl;
	logic              cfg_acc, cfg_hit, in_acc, out_free, nrdy, srdy, fetch_ok;
	logic              load_ins, last_emit, gen_step, gen_push, gen_end, row_inc;
	logic              gen_rot_l, gen_rot_u, re_rot_l, re_rot_u, l_ok, u_ok;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		unique case (cfg_index) inside
			CFG_NUM_ROWS, CFG_NUM_FACES: cfg_hit = 1'b1;
			default:                     cfg_hit = 1'b0;
		endcase
	end

	always_comb begin
		nf = (num_faces_q > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES) : num_faces_q;
		if (num_rows_q == '0) begin
			nr = CNT_W'(1);
		end else if (num_rows_q > CNT_W'(MAX_ROWS)) begin
			nr = CNT_W'(MAX_ROWS);
		end else begin
			nr = num_rows_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign nrdy     = !stream_q && (count_q < nf);
	assign srdy     = stream_q && ((bcnt_q == 2'd2) || (end_q && (bcnt_q != 2'd0)));
	assign fetch_ok = !realign_q && (nrdy || srdy);
	assign in_stall = in_data.kind ? !(fetch_ok && out_free) : realign_q;
	assign in_acc   = in_valid && !in_stall;

	assign load_ins  = in_acc && !in_data.kind && !stream_q && (count_q < nf);
	assign last_emit = in_acc && in_data.kind && srdy && (bcnt_q == 2'd1);

	always_comb begin
		resp = '0;
		if (nrdy) begin
			resp.status = 1'b1;
		end else begin
			resp            = buf0_q;
			resp.last_entry = (bcnt_q == 2'd1);
		end
	end

	// generator
	assign l_ok     = lhead.vld && (lpop_q < count_q);
	assign u_ok     = uhead.vld && (upop_q < count_q);
	assign gen_step = gen_on_q && (bcnt_q != 2'd2);

	always_comb begin
		gen_push  = 1'b0;
		gen_end   = 1'b0;
		row_inc   = 1'b0;
		gen_rot_l = 1'b0;
		gen_rot_u = 1'b0;
		ph_d      = ph_q;
		gen_e     = '0;
		gen_e.row_index = row_q;
		if (gen_step) begin
			unique case (ph_q)
				PH_LOWER: begin
					if (l_ok && ({1'b0, lhead.face} >= nf)) begin
						gen_rot_l = 1'b1;
					end else if (l_ok && (lhead.nb == row_q)) begin
						gen_rot_l        = 1'b1;
						gen_push         = 1'b1;
						gen_e.col_index  = lhead.owner;
						gen_e.value_slot = SLOT_W'(nf) + SLOT_W'(lhead.face);
					end else begin
						ph_d = PH_DIAG;
					end
				end
				PH_DIAG: begin
					gen_push         = 1'b1;
					gen_e.col_index  = row_q;
					gen_e.value_slot = SLOT_W'({nf, 1'b0}) + SLOT_W'(row_q);
					ph_d             = PH_UPPER;
				end
				PH_UPPER: begin
					if (u_ok && ({1'b0, uhead.face} >= nf)) begin
						gen_rot_u = 1'b1;
					end else if (u_ok && (uhead.owner == row_q)) begin
						gen_rot_u        = 1'b1;
						gen_push         = 1'b1;
						gen_e.col_index  = uhead.nb;
						gen_e.value_slot = SLOT_W'(uhead.face);
					end else if ((CNT_W'(row_q) + CNT_W'(1)) >= nr) begin
						gen_end = 1'b1;
					end else begin
						row_inc = 1'b1;
						ph_d    = PH_LOWER;
					end
				end
				default: ph_d = PH_LOWER;
			endcase
		end
	end

	assign re_rot_l = realign_q && (lpop_q[FACE_W-1:0] != '0);
	assign re_rot_u = realign_q && (upop_q[FACE_W-1:0] != '0);

	always_comb begin
		new_c       = '0;
		new_c.vld   = 1'b1;
		new_c.owner = in_data.owner_cell;
		new_c.nb    = in_data.neighbour_cell;
		new_c.face  = count_q[FACE_W-1:0];
		lctl.ins    = load_ins;
		lctl.rot    = gen_rot_l || re_rot_l;
		lctl.clr    = last_emit;
		uctl.ins    = load_ins;
		uctl.rot    = gen_rot_u || re_rot_u;
		uctl.clr    = last_emit;
	end

	ldcs_chain u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lctl),
		.by_nb  (1'b1),
		.new_c  (new_c),
		.head   (lhead)
	);

	ldcs_chain u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (uctl),
		.by_nb  (1'b0),
		.new_c  (new_c),
		.head   (uhead)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= CNT_W'(1);
			num_faces_q <= '0;
			count_q     <= '0;
			lpop_q      <= '0;
			upop_q      <= '0;
			stream_q    <= 1'b0;
			gen_on_q    <= 1'b0;
			end_q       <= 1'b0;
			realign_q   <= 1'b0;
			bcnt_q      <= 2'd0;
			row_q       <= '0;
			ph_q        <= PH_LOWER;
			out_valid_q <= 1'b0;
		end else begin
			if (lctl.rot) begin
				lpop_q <= lpop_q + CNT_W'(1);
			end
			if (uctl.rot) begin
				upop_q <= upop_q + CNT_W'(1);
			end
			if (load_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (gen_step) begin
				ph_q <= ph_d;
				if (row_inc) begin
					row_q <= row_q + CELL_W'(1);
				end
				if (gen_end) begin
					end_q    <= 1'b1;
					gen_on_q <= 1'b0;
				end
			end
			if (gen_push) begin
				bcnt_q <= bcnt_q + 2'd1;
			end
			if (in_acc && in_data.kind && srdy) begin
				bcnt_q <= bcnt_q - 2'd1;
			end
			if (realign_q && !re_rot_l && !re_rot_u) begin
				realign_q <= 1'b0;
				lpop_q    <= '0;
				upop_q    <= '0;
			end
			if (!stream_q && !realign_q && (count_q >= nf) && !cfg_acc) begin
				stream_q <= 1'b1;
				gen_on_q <= 1'b1;
				end_q    <= 1'b0;
				bcnt_q   <= 2'd0;
				row_q    <= '0;
				ph_q     <= PH_LOWER;
				lpop_q   <= '0;
				upop_q   <= '0;
			end
			if (last_emit) begin
				stream_q <= 1'b0;
				gen_on_q <= 1'b0;
				end_q    <= 1'b0;
				bcnt_q   <= 2'd0;
				count_q  <= '0;
				lpop_q   <= '0;
				upop_q   <= '0;
			end
			if (cfg_acc && cfg_hit) begin
				if (cfg_index == CFG_NUM_ROWS) begin
					num_rows_q <= cfg_data;
				end else begin
					num_faces_q <= cfg_data;
				end
				stream_q  <= 1'b0;
				gen_on_q  <= 1'b0;
				end_q     <= 1'b0;
				bcnt_q    <= 2'd0;
				realign_q <= 1'b1;
			end
			if (in_acc && in_data.kind) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_push) begin
			if (bcnt_q == 2'd0) begin
				buf0_q <= gen_e;
			end else begin
				buf1_q <= gen_e;
			end
		end
		if (in_acc && in_data.kind && srdy) begin
			buf0_q <= buf1_q;
		end
		if (in_acc && in_data.kind) begin
			out_q <= resp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q != 2'd3) else $error("lookahead buffer overfilled");
	a_realign_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(realign_q && stream_q)) else $error("realign during stream");
	a_pop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stream_q |-> (lpop_q <= count_q) && (upop_q <= count_q))
		else $error("chain read beyond loaded faces");
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last_entry |-> !out_q.status)
		else $error("last entry flagged on not-ready status");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		gen_push |-> (bcnt_q != 2'd2) && !end_q)
		else $error("push into full buffer");
`endif

endmodule
